>>> rtl/cffa_pkg.sv
// Package for the comb filter block: sizes, register map and mode codes.
// Used by the channel interfaces, the top level and the port checker.
package cffa_pkg;

  localparam int MAX_DELAY   = 4096;
  localparam int SAMPLE_BITS = 16;

  // fixed field widths of the configuration registers
  localparam int MODE_W = 2;
  localparam int GAIN_W = 16;
  localparam int DLY_W  = 13;

  localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CNT_W = $clog2(MAX_DELAY + 1);

  // APB map: register i at byte address 4*i
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_GAIN  = 2'd1,
    REG_DELAY = 2'd2
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FF = 2'd0,
    MODE_FB = 2'd1,
    MODE_AP = 2'd2
  } mode_t;

endpackage

>>> rtl/cffa_ifs.sv
// Valid/ready channel interfaces for the comb filter: input items and result items.
// Depends on cffa_pkg for the sample width.
interface cffa_in_if import cffa_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [SAMPLE_BITS-1:0] aux_sample;
  logic                          block_start;

  modport source (output valid, sample_in, aux_sample, block_start, input ready);
  modport sink   (input valid, sample_in, aux_sample, block_start, output ready);
endinterface

interface cffa_out_if import cffa_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

>>> rtl/comb_filter_ff_fb_allpass_top.sv
// Comb filter (feedforward, feedback, allpass) top level with APB register port.
// Depends on cffa_pkg, cffa_ifs (channels) and cffa_ram (delay line).
// Path from input accept to result valid: delay-line read, then result register.
// Throughput: one item per cycle unless out_ch stalls; the delay-line RAM has one write
// and one read port, and a delay of one is served by forwarding the previous result.
// Reset: rst (synchronous) empties the pipeline, clears write pointer and fill count,
// and sets mode 0, gain 0, delay 1. Delay-line contents stay undefined until written.
module comb_filter_ff_fb_allpass_top import cffa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  cffa_in_if.sink           in_ch,
  cffa_out_if.source        out_ch
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = 2 * SB;       // product width
  localparam int MW = SB + 1;       // rounded product width
  localparam int AW = SB + 3;       // accumulator width
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (SB - 2);
  localparam logic signed [AW-1:0] SAT_HI = AW'((1 <<< (SB - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

  // configuration registers
  logic [MODE_W-1:0]        mode;
  logic signed [GAIN_W-1:0] gain;
  logic [DLY_W-1:0]         delay;

  // stream state
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] fill_cnt;

  // stage 1: item waiting on delay-line read data
  logic                   s1_valid;
  logic signed [SB-1:0]   s1_x;
  logic signed [SB-1:0]   s1_aux;
  logic                   s1_have_past;
  logic [PTR_W-1:0]       s1_waddr;
  logic                   s1_fwd;
  logic signed [SB-1:0]   fwd_data;

  // result register
  logic                 out_valid;
  logic signed [SB-1:0] out_sample;
  logic                 out_sat;

  logic                 in_fire;
  logic                 s1_fire;
  logic                 wr_cfg;
  logic [CNT_W-1:0]     d_eff;
  logic [CNT_W-1:0]     fc_cur;
  logic [CNT_W-1:0]     fill_next;
  logic                 have_past;
  logic [PTR_W:0]       rd_wide;
  logic [PTR_W-1:0]     rd_addr;
  logic [PTR_W-1:0]     wr_ptr_next;
  logic [SB-1:0]        ram_rdata;
  logic signed [SB-1:0] past;
  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_p;
  logic signed [MW-1:0] term_a;
  logic signed [MW-1:0] term_p;
  logic signed [AW-1:0] acc;
  logic signed [SB-1:0] acc_sat;
  logic                 sat_flag;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_FF;
      gain  <= '0;
      delay <= DLY_W'(1);
    end else if (wr_cfg) begin
      case (reg_idx_t'(paddr[ADDR_W-1:2]))
        REG_MODE:  mode  <= pwdata[MODE_W-1:0];
        REG_GAIN:  gain  <= pwdata[GAIN_W-1:0];
        REG_DELAY: delay <= pwdata[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_MODE:  prdata = DATA_W'(mode);
      REG_GAIN:  prdata = DATA_W'($unsigned(gain));
      REG_DELAY: prdata = DATA_W'(delay);
      default:   prdata = '0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign s1_fire     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // ---------------- accept side: history and read address ----------------
  always_comb begin
    if (delay == '0) begin
      d_eff = CNT_W'(1);
    end else if ({1'b0, delay} > (DLY_W + 1)'(MAX_DELAY)) begin
      d_eff = CNT_W'(MAX_DELAY);
    end else begin
      d_eff = CNT_W'(delay);
    end

    fc_cur    = in_ch.block_start ? '0 : fill_cnt;
    have_past = fc_cur >= d_eff;
    fill_next = (fc_cur < CNT_W'(MAX_DELAY)) ? fc_cur + CNT_W'(1) : fc_cur;

    // circular read address wr_ptr - d
    if ((PTR_W + 1)'(wr_ptr) >= (PTR_W + 1)'(d_eff)) begin
      rd_wide = (PTR_W + 1)'(wr_ptr) - (PTR_W + 1)'(d_eff);
    end else begin
      rd_wide = (PTR_W + 1)'(wr_ptr) + (PTR_W + 1)'(MAX_DELAY) - (PTR_W + 1)'(d_eff);
    end
    rd_addr = rd_wide[PTR_W-1:0];

    wr_ptr_next = (wr_ptr == PTR_W'(MAX_DELAY - 1)) ? '0 : wr_ptr + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      fill_cnt <= '0;
    end else if (in_fire) begin
      wr_ptr   <= wr_ptr_next;
      fill_cnt <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x         <= in_ch.sample_in;
      s1_aux       <= in_ch.aux_sample;
      s1_have_past <= have_past;
      s1_waddr     <= wr_ptr;
      // the entry being read is written at this same edge: take it from the result
      s1_fwd       <= s1_fire && (rd_addr == s1_waddr);
      fwd_data     <= acc_sat;
    end
  end

  cffa_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_DELAY)
  ) u_dline (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_waddr),
    .wdata (acc_sat),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------- stage 1 arithmetic ----------------
  assign past = s1_fwd ? fwd_data : $signed(ram_rdata);

  always_comb begin
    // first product: g*x in allpass, g*aux otherwise
    if (mode_t'(mode) == MODE_AP) begin
      prod_a = PW'(gain) * PW'(s1_x) + RND;
    end else begin
      prod_a = PW'(gain) * PW'(s1_aux) + RND;
    end
    prod_p = PW'(gain) * PW'(past) + RND;
    term_a = prod_a[PW-1:SB-1];
    term_p = prod_p[PW-1:SB-1];

    case (mode_t'(mode))
      MODE_FB: begin
        acc = AW'(s1_x) + (s1_have_past ? AW'(term_p) : '0);
      end
      MODE_AP: begin
        acc = AW'(term_a) + AW'(s1_aux) - (s1_have_past ? AW'(term_p) : '0);
      end
      default: begin
        acc = AW'(s1_x) + AW'(term_a);
      end
    endcase

    if (acc > SAT_HI) begin
      acc_sat  = SAT_HI[SB-1:0];
      sat_flag = 1'b1;
    end else if (acc < SAT_LO) begin
      acc_sat  = SAT_LO[SB-1:0];
      sat_flag = 1'b1;
    end else begin
      acc_sat  = acc[SB-1:0];
      sat_flag = 1'b0;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_sample <= acc_sat;
      out_sat    <= sat_flag;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.saturated  = out_sat;

endmodule

>>> rtl/cffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cffa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cffa_checker.sv
// Port-level checker for the comb filter top level, attached by bind.
// Depends on cffa_pkg for the sample width.
module cffa_checker import cffa_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          saturated
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an item taken while the output is empty leads to a valid result after stage 1 and the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && !out_valid |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // reset leaves no result on the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a clipped result sits at one end of the range
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (sample_out == S_MAX) || (sample_out == S_MIN))
    else $error("saturated flag with unclipped value");

endmodule

bind comb_filter_ff_fb_allpass_top cffa_checker u_cffa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .saturated  (out_ch.saturated)
);

>>> dv/tb_top.sv
// Testbench for the comb filter top level: APB setup, item streams and a built-in predictor.
// Depends on cffa_pkg, the cffa_in_if/cffa_out_if channels and the RTL top module.
`timescale 1ns / 100ps

module tb_top;
  import cffa_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          sat;
  } comb_out_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cffa_in_if  in_ch();
  cffa_out_if out_ch();

  comb_filter_ff_fb_allpass_top DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the filter state and registers
  logic signed [SAMPLE_BITS-1:0] hist [MAX_DELAY];
  int                            wr_ptr;
  int                            fill_cnt;
  logic [MODE_W-1:0]             cfg_mode;
  logic signed [GAIN_W-1:0]      cfg_gain;
  logic [DLY_W-1:0]              cfg_delay;

  comb_out_t filtered_q[$];
  int        mismatches;
  bit        in_idle_en;
  bit        out_idle_en;
  int        hold_req;

  // product rounded half up, then floor shift back to sample scale
  function automatic int round_mul(input int a, input int b);
    int p;
    p = a * b + (1 << (SAMPLE_BITS - 2));
    return p >>> (SAMPLE_BITS - 1);
  endfunction

  function automatic comb_out_t comb_predict(input logic signed [SAMPLE_BITS-1:0] x,
                                             input logic signed [SAMPLE_BITS-1:0] aux,
                                             input logic bs);
    int        lim;
    int        d;
    int        rd;
    int        past;
    int        acc;
    int        g;
    bit        have_past;
    comb_out_t r;
    lim = 1 << (SAMPLE_BITS - 1);
    g = cfg_gain;
    if (bs) fill_cnt = 0;
    d = cfg_delay;
    if (d < 1) d = 1;
    if (d > MAX_DELAY) d = MAX_DELAY;
    have_past = (fill_cnt >= d);
    past = 0;
    if (have_past) begin
      rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + MAX_DELAY - d;
      past = hist[rd];
    end
    case (cfg_mode)
      MODE_FB: begin
        acc = x;
        if (have_past) acc += round_mul(g, past);
      end
      MODE_AP: begin
        acc = round_mul(g, x) + aux;
        if (have_past) acc -= round_mul(g, past);
      end
      default: acc = x + round_mul(g, aux);
    endcase
    r.sat = 1'b0;
    if (acc > lim - 1) begin
      acc = lim - 1;
      r.sat = 1'b1;
    end else if (acc < -lim) begin
      acc = -lim;
      r.sat = 1'b1;
    end
    r.y = acc[SAMPLE_BITS-1:0];
    hist[wr_ptr] = r.y;
    wr_ptr = (wr_ptr + 1 >= MAX_DELAY) ? 0 : wr_ptr + 1;
    if (fill_cnt < MAX_DELAY) fill_cnt++;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // write one register, then read it back
  task automatic set_reg(input reg_idx_t r, input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] mask;
    case (r)
      REG_MODE: begin
        mask = DATA_W'((1 << MODE_W) - 1);
        cfg_mode = v[MODE_W-1:0];
      end
      REG_GAIN: begin
        mask = DATA_W'((1 << GAIN_W) - 1);
        cfg_gain = v[GAIN_W-1:0];
      end
      REG_DELAY: begin
        mask = DATA_W'((1 << DLY_W) - 1);
        cfg_delay = v[DLY_W-1:0];
      end
      default: mask = '0;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(r) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (v & mask)) begin
      $display("%0t: register %s readback expected %0h actual %0h",
               $time, r.name(), v & mask, prdata & mask);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] x,
                           input logic signed [SAMPLE_BITS-1:0] aux,
                           input logic bs);
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_in   <= x;
    in_ch.aux_sample  <= aux;
    in_ch.block_start <= bs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    filtered_q.push_back(comb_predict(x, aux, bs));
  endtask

  // hold off input until every pending result is out, then let the pipe settle
  task automatic drain_filter();
    in_ch.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_result();
    comb_out_t e;
    if (filtered_q.size() == 0) begin
      $display("%0t: result with nothing pending, actual y=%0d sat=%0b",
               $time, out_ch.sample_out, out_ch.saturated);
      mismatches++;
    end else begin
      e = filtered_q.pop_front();
      if (out_ch.sample_out !== e.y) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.y, out_ch.sample_out);
        mismatches++;
      end
      if (out_ch.saturated !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, out_ch.saturated);
        mismatches++;
      end
    end
  endtask

  // result side: check each accepted item, drive ready with stalls and long holds
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    // reset values: feedforward, zero gain, so y follows x
    send_item(16'sh7FFF, 16'sh8000, 1'b1);
    send_item(16'sh8000, 16'sh7FFF, 1'b0);
    drain_filter();
    set_reg(REG_GAIN, 32'h0000_7FFF);
    send_item(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(16'sh8000, 16'sh8000, 1'b0);
    drain_filter();
    set_reg(REG_GAIN, 32'h0000_8000);
    send_item(16'sh0000, 16'sh8000, 1'b0);
    send_item(-16'sd1, 16'sd1, 1'b0);
    drain_filter();
    // no block start: feedback picks up outputs written in feedforward mode
    set_reg(REG_MODE, MODE_FB);
    set_reg(REG_DELAY, 32'd1);
    send_item(16'sh8000, 16'sd3, 1'b0);
    send_item(16'sh7FFF, -16'sd3, 1'b0);
    send_item(16'sd100, 16'sd0, 1'b0);
    drain_filter();
    set_reg(REG_DELAY, 32'd0);
    send_item(16'sd1234, 16'sh7FFF, 1'b1);
    send_item(-16'sd4321, 16'sh8000, 1'b0);
    drain_filter();
    set_reg(REG_MODE, MODE_AP);
    set_reg(REG_GAIN, 32'h0000_4000);
    set_reg(REG_DELAY, 32'd2);
    send_item(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_item(16'sh8000, 16'sh0001, 1'b0);
    send_item(16'sd5000, -16'sd7000, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 1'b0);
    drain_filter();
    set_reg(REG_MODE, 32'd3);
    send_item(16'sd20000, 16'sd30000, 1'b0);
    send_item(-16'sd20000, -16'sd30000, 1'b0);
    drain_filter();
    // out-of-range delay clamps to the line length, so no history yet
    set_reg(REG_MODE, MODE_FB);
    set_reg(REG_DELAY, (1 << DLY_W) - 1);
    send_item(16'sd77, 16'sd0, 1'b0);
    send_item(16'sh8000, 16'sh7FFF, 1'b0);
    drain_filter();
  endtask

  task automatic test_backpressure();
    set_reg(REG_MODE, MODE_FB);
    set_reg(REG_GAIN, 32'd12000);
    set_reg(REG_DELAY, 32'd3);
    in_idle_en = 1'b0;
    hold_req = 120;
    for (int i = 0; i < 48; i++) send_item(pick_sample(), pick_sample(), i == 0);
    // pause the sender until the filter is empty
    drain_filter();
    in_idle_en = 1'b1;
    for (int i = 0; i < 16; i++) send_item(pick_sample(), pick_sample(), 1'b0);
    drain_filter();
  endtask

  task automatic test_random();
    int n;
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] d;
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(REG_MODE, DATA_W'($urandom_range(0, (1 << MODE_W) - 1)));
      case ($urandom_range(0, 7))
        0: g = 32'h0000_7FFF;
        1: g = 32'h0000_8000;
        2: g = DATA_W'(16'($urandom_range(0, 16383) - 8192));
        default: g = DATA_W'(16'($urandom));
      endcase
      set_reg(REG_GAIN, g);
      case ($urandom_range(0, 9))
        0: d = 0;
        1: d = $urandom_range(MAX_DELAY + 1, (1 << DLY_W) - 1);
        2: d = $urandom_range(17, 300);
        default: d = $urandom_range(1, 16);
      endcase
      set_reg(REG_DELAY, d);
      n = $urandom_range(80, 130);
      // mostly whole blocks; stray block starts now and then
      for (int i = 0; i < n; i++)
        send_item(pick_sample(), pick_sample(),
                  (i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 59) == 0);
      drain_filter();
    end
  endtask

  // long delay at full rate, with one restart partway through
  task automatic test_full_rate();
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    set_reg(REG_MODE, MODE_FB);
    set_reg(REG_GAIN, 32'h0000_A000);
    set_reg(REG_DELAY, 32'd120);
    for (int i = 0; i < 420; i++)
      send_item(pick_sample(), pick_sample(), i == 0 || i == 260);
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.sample_in   <= '0;
    in_ch.aux_sample  <= '0;
    in_ch.block_start <= 1'b0;
    mismatches  = 0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    hold_req    = 0;
    wr_ptr      = 0;
    fill_cnt    = 0;
    cfg_mode    = MODE_FF;
    cfg_gain    = '0;
    cfg_delay   = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_full_rate();
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(6_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
